// ===== rtl/core/dual_fifo_unique_admission_top_defines.svh =====
// Assertion macros shared by the RTL of the dual FIFO block.
`ifndef DUAL_FIFO_UNIQUE_ADMISSION_TOP_DEFINES_SVH
`define DUAL_FIFO_UNIQUE_ADMISSION_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DFUA_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dfua assertion failed");

// Next-cycle implication, disabled during reset.
`define DFUA_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dfua assertion failed");

`endif

// ===== rtl/core/dfua_pkg.sv =====
`default_nettype none

package dfua_pkg;

  localparam int unsigned DEPTH_DEF    = 16;
  localparam int unsigned ID_WIDTH_DEF = 16;

  localparam int unsigned STATUS_W = 3;
  localparam logic [STATUS_W-1:0] ST_OK    = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_FULL  = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_DUP_A = STATUS_W'(2);
  localparam logic [STATUS_W-1:0] ST_DUP_B = STATUS_W'(3);
  localparam logic [STATUS_W-1:0] ST_EMPTY = STATUS_W'(4);

  // Microprogram step addresses
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] S_FETCH  = STEP_W'(0);
  localparam logic [STEP_W-1:0] S_DECODE = STEP_W'(1);
  localparam logic [STEP_W-1:0] S_ENQ    = STEP_W'(2);
  localparam logic [STEP_W-1:0] S_SCAN   = STEP_W'(3);
  localparam logic [STEP_W-1:0] S_CMP    = STEP_W'(4);
  localparam logic [STEP_W-1:0] S_NEXTQ  = STEP_W'(5);
  localparam logic [STEP_W-1:0] S_WRITE  = STEP_W'(6);
  localparam logic [STEP_W-1:0] S_DEQ    = STEP_W'(7);
  localparam logic [STEP_W-1:0] S_DEQCAP = STEP_W'(8);
  localparam logic [STEP_W-1:0] S_EMIT   = STEP_W'(9);

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_KIND_DEQ,
    C_SEL_FULL,
    C_SCAN_DONE,
    C_MATCH,
    C_SCAN_ON_B,
    C_SEL_EMPTY,
    C_OUT_FREE
  } cond_sel_t;

  typedef enum logic [1:0] {
    W_ALWAYS,
    W_TRUE,
    W_FALSE
  } act_when_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_SCAN_A,
    OP_SCAN_B,
    OP_SCAN_RD,
    OP_WRITE,
    OP_DEQ_RD,
    OP_DEQ_CAP,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    SS_KEEP,
    SS_FULL,
    SS_DUP,
    SS_EMPTY
  } stat_sel_t;

  typedef struct packed {
    cond_sel_t         cond;
    act_when_t         act_when;
    op_t               op;
    stat_sel_t         ss;
    logic [STEP_W-1:0] next_t;
    logic [STEP_W-1:0] next_f;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic kind_deq;
    logic sel_full;
    logic scan_done;
    logic match;
    logic scan_on_b;
    logic sel_empty;
    logic out_free;
  } flags_t;

  typedef struct packed {
    op_t       op;
    logic      fire;
    logic      set_status;
    stat_sel_t ss;
  } ctrl_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    unique case (step)
      S_FETCH:  w = '{C_IN_VALID,  W_TRUE,   OP_LATCH,   SS_KEEP,  S_DECODE, S_FETCH};
      S_DECODE: w = '{C_KIND_DEQ,  W_ALWAYS, OP_NONE,    SS_KEEP,  S_DEQ,    S_ENQ};
      S_ENQ:    w = '{C_SEL_FULL,  W_ALWAYS, OP_SCAN_A,  SS_FULL,  S_EMIT,   S_SCAN};
      S_SCAN:   w = '{C_SCAN_DONE, W_FALSE,  OP_SCAN_RD, SS_KEEP,  S_NEXTQ,  S_CMP};
      S_CMP:    w = '{C_MATCH,     W_ALWAYS, OP_NONE,    SS_DUP,   S_EMIT,   S_SCAN};
      S_NEXTQ:  w = '{C_SCAN_ON_B, W_FALSE,  OP_SCAN_B,  SS_KEEP,  S_WRITE,  S_SCAN};
      S_WRITE:  w = '{C_ALWAYS,    W_ALWAYS, OP_WRITE,   SS_KEEP,  S_EMIT,   S_EMIT};
      S_DEQ:    w = '{C_SEL_EMPTY, W_FALSE,  OP_DEQ_RD,  SS_EMPTY, S_EMIT,   S_DEQCAP};
      S_DEQCAP: w = '{C_ALWAYS,    W_ALWAYS, OP_DEQ_CAP, SS_KEEP,  S_EMIT,   S_EMIT};
      S_EMIT:   w = '{C_OUT_FREE,  W_TRUE,   OP_EMIT,    SS_KEEP,  S_FETCH,  S_EMIT};
      default:  w = '{C_ALWAYS,    W_ALWAYS, OP_NONE,    SS_KEEP,  S_FETCH,  S_FETCH};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dfua_ram.sv =====
`default_nettype none

module dfua_ram #(
  parameter int unsigned WIDTH = dfua_pkg::ID_WIDTH_DEF,
  parameter int unsigned DEPTH = dfua_pkg::DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/dfua_seq.sv =====
`default_nettype none

module dfua_seq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire dfua_pkg::flags_t flags,
  output dfua_pkg::ctrl_t      ctrl
);

  logic [dfua_pkg::STEP_W-1:0] step;
  logic [dfua_pkg::STEP_W-1:0] step_next;
  dfua_pkg::ucode_t            word;
  logic                        cond_true;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= dfua_pkg::S_FETCH;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    word = dfua_pkg::ucode_rom(step);
    unique case (word.cond)
      dfua_pkg::C_ALWAYS:    cond_true = 1'b1;
      dfua_pkg::C_IN_VALID:  cond_true = flags.in_valid;
      dfua_pkg::C_KIND_DEQ:  cond_true = flags.kind_deq;
      dfua_pkg::C_SEL_FULL:  cond_true = flags.sel_full;
      dfua_pkg::C_SCAN_DONE: cond_true = flags.scan_done;
      dfua_pkg::C_MATCH:     cond_true = flags.match;
      dfua_pkg::C_SCAN_ON_B: cond_true = flags.scan_on_b;
      dfua_pkg::C_SEL_EMPTY: cond_true = flags.sel_empty;
      dfua_pkg::C_OUT_FREE:  cond_true = flags.out_free;
      default:               cond_true = 1'b0;
    endcase

    ctrl.op = word.op;
    ctrl.ss = word.ss;
    ctrl.set_status = cond_true && (word.ss != dfua_pkg::SS_KEEP);
    unique case (word.act_when)
      dfua_pkg::W_ALWAYS: ctrl.fire = 1'b1;
      dfua_pkg::W_TRUE:   ctrl.fire = cond_true;
      dfua_pkg::W_FALSE:  ctrl.fire = !cond_true;
      default:            ctrl.fire = 1'b0;
    endcase

    step_next = cond_true ? word.next_t : word.next_f;
  end

endmodule

`default_nettype wire

// ===== rtl/core/dual_fifo_unique_admission_top.sv =====
// Dequeue: latch, decode, read and capture the head entry, then emit; an empty queue skips
//   the read and capture. Enqueue, when admitted, scans queue a then queue b before the
//   write; each held entry takes a read step and a compare step behind the registered RAM
//   read port. A full queue skips the scan; the next transaction is taken after the emit.
// Reset (rst, synchronous, active high): pointers and counts go to zero, the
//   microprogram returns to fetch; the stores are not cleared.
`default_nettype none

`include "dual_fifo_unique_admission_top_defines.svh"

module dual_fifo_unique_admission_top #(
  parameter int unsigned DEPTH    = dfua_pkg::DEPTH_DEF,
  parameter int unsigned ID_WIDTH = dfua_pkg::ID_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               item_valid,
  output logic                                    item_stall,
  input  wire logic                               kind,
  input  wire logic                               queue_sel,
  input  wire logic [ID_WIDTH-1:0]                ident,
  output logic                                    result_valid,
  input  wire logic                               result_stall,
  output logic [dfua_pkg::STATUS_W-1:0]           status,
  output logic [ID_WIDTH-1:0]                     head_item,
  output logic [$clog2(DEPTH+1)-1:0]              occupancy_a,
  output logic [$clog2(DEPTH+1)-1:0]              occupancy_b
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SW    = CNT_W + 1;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  dfua_pkg::flags_t flags;
  dfua_pkg::ctrl_t  ctrl;

  logic [AW-1:0]    head_a, tail_a, head_b, tail_b;
  logic [CNT_W-1:0] fill_a, fill_b;

  logic                          kind_reg, sel_reg;
  logic [ID_WIDTH-1:0]           ident_reg;
  logic [dfua_pkg::STATUS_W-1:0] status_reg;
  logic [dfua_pkg::STATUS_W-1:0] status_set;
  logic [ID_WIDTH-1:0]           item_reg;
  logic                          scan_q;
  logic [CNT_W-1:0]              scan_idx;
  logic [AW-1:0]                 scan_ptr;

  logic [CNT_W-1:0]    fill_sel, scan_fill;
  logic [AW-1:0]       head_sel, raddr;
  logic [ID_WIDTH-1:0] rdata_a, rdata_b, rdata_sel;
  logic                we_a, we_b;

  dfua_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  dfua_ram #(.WIDTH(ID_WIDTH), .DEPTH(DEPTH)) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (tail_a),
    .wdata (ident_reg),
    .raddr (raddr),
    .rdata (rdata_a)
  );

  dfua_ram #(.WIDTH(ID_WIDTH), .DEPTH(DEPTH)) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (tail_b),
    .wdata (ident_reg),
    .raddr (raddr),
    .rdata (rdata_b)
  );

  assign item_stall = (ctrl.op != dfua_pkg::OP_LATCH);

  always_comb begin
    fill_sel  = sel_reg ? fill_b : fill_a;
    head_sel  = sel_reg ? head_b : head_a;
    scan_fill = scan_q ? fill_b : fill_a;
    raddr     = (ctrl.op == dfua_pkg::OP_DEQ_RD) ? head_sel : scan_ptr;
    // dequeue capture reads the selected queue, a compare reads the scanned one
    rdata_sel = ((ctrl.op == dfua_pkg::OP_DEQ_CAP) ? sel_reg : scan_q) ? rdata_b : rdata_a;
    we_a      = ctrl.fire && (ctrl.op == dfua_pkg::OP_WRITE) && !sel_reg;
    we_b      = ctrl.fire && (ctrl.op == dfua_pkg::OP_WRITE) && sel_reg;

    flags.in_valid  = item_valid;
    flags.kind_deq  = kind_reg;
    flags.sel_full  = (fill_sel == CNT_W'(DEPTH));
    flags.scan_done = (scan_idx == scan_fill);
    flags.match     = (rdata_sel == ident_reg);
    flags.scan_on_b = scan_q;
    flags.sel_empty = (fill_sel == '0);
    flags.out_free  = !result_valid || !result_stall;

    case (ctrl.ss)
      dfua_pkg::SS_FULL:  status_set = dfua_pkg::ST_FULL;
      dfua_pkg::SS_DUP:   status_set = scan_q ? dfua_pkg::ST_DUP_B : dfua_pkg::ST_DUP_A;
      dfua_pkg::SS_EMPTY: status_set = dfua_pkg::ST_EMPTY;
      default:            status_set = status_reg;
    endcase
  end

  // Queue pointers, counts and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      head_a       <= '0;
      tail_a       <= '0;
      fill_a       <= '0;
      head_b       <= '0;
      tail_b       <= '0;
      fill_b       <= '0;
      result_valid <= 1'b0;
    end else begin
      if (ctrl.fire && (ctrl.op == dfua_pkg::OP_EMIT)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (ctrl.fire) begin
        case (ctrl.op)
          dfua_pkg::OP_WRITE: begin
            if (sel_reg) begin
              tail_b <= ptr_inc(tail_b);
              fill_b <= fill_b + 1'b1;
            end else begin
              tail_a <= ptr_inc(tail_a);
              fill_a <= fill_a + 1'b1;
            end
          end
          dfua_pkg::OP_DEQ_RD: begin
            if (sel_reg) begin
              head_b <= ptr_inc(head_b);
              fill_b <= fill_b - 1'b1;
            end else begin
              head_a <= ptr_inc(head_a);
              fill_a <= fill_a - 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Transaction payload, scan state and result fields
  always_ff @(posedge clk) begin
    if (ctrl.set_status) begin
      status_reg <= status_set;
    end
    if (ctrl.fire) begin
      case (ctrl.op)
        dfua_pkg::OP_LATCH: begin
          kind_reg   <= kind;
          sel_reg    <= queue_sel;
          ident_reg  <= ident;
          status_reg <= dfua_pkg::ST_OK;
          item_reg   <= '0;
        end
        dfua_pkg::OP_SCAN_A: begin
          scan_q   <= 1'b0;
          scan_idx <= '0;
          scan_ptr <= head_a;
        end
        dfua_pkg::OP_SCAN_B: begin
          scan_q   <= 1'b1;
          scan_idx <= '0;
          scan_ptr <= head_b;
        end
        dfua_pkg::OP_SCAN_RD: begin
          scan_idx <= scan_idx + 1'b1;
          scan_ptr <= ptr_inc(scan_ptr);
        end
        dfua_pkg::OP_DEQ_CAP: item_reg <= rdata_sel;
        dfua_pkg::OP_EMIT: begin
          status      <= status_reg;
          head_item   <= item_reg;
          occupancy_a <= fill_a;
          occupancy_b <= fill_b;
        end
        default: ;
      endcase
    end
  end

  // Ring consistency: tail sits fill entries past head
  logic [SW-1:0] sum_a, sum_b;
  logic [AW-1:0] ring_end_a, ring_end_b;

  always_comb begin
    sum_a      = SW'(head_a) + SW'(fill_a);
    sum_b      = SW'(head_b) + SW'(fill_b);
    ring_end_a = (sum_a >= SW'(DEPTH)) ? AW'(sum_a - SW'(DEPTH)) : AW'(sum_a);
    ring_end_b = (sum_b >= SW'(DEPTH)) ? AW'(sum_b - SW'(DEPTH)) : AW'(sum_b);
  end

  `DFUA_ASSERT_IMPL(a_ring_a, clk, rst, 1'b1, tail_a == ring_end_a)
  `DFUA_ASSERT_IMPL(a_ring_b, clk, rst, 1'b1, tail_b == ring_end_b)
  `DFUA_ASSERT_IMPL(a_write_room, clk, rst, we_a || we_b, fill_sel != CNT_W'(DEPTH))
  `DFUA_ASSERT_NEXT(a_write_a_grows, clk, rst, we_a, fill_a == $past(fill_a) + 1'b1)
  `DFUA_ASSERT_IMPL(a_empty_zero, clk, rst, result_valid && (status == dfua_pkg::ST_EMPTY), head_item == '0)

endmodule

`default_nettype wire
